/* rtl/i2ctci_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2ctci_pkg
// Shared types and constants of the bus target command interface.
// ----------------------------------------------------------------------------
package i2ctci_pkg;

    // sample store geometry: two banks of equal size
    localparam int unsigned BANK_BYTES  = 40;
    localparam int unsigned STORE_DEPTH = 2 * BANK_BYTES;
    localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

    // load index codes for the adc values
    localparam logic [5:0] LOAD_ADC0 = 6'd40;
    localparam logic [5:0] LOAD_ADC1 = 6'd41;

    // own address reset value and general call address
    localparam logic [6:0] OWN_ADDRESS_RST = 7'd24;
    localparam logic [7:0] GENERAL_CALL    = 8'h00;

    // register indexes
    localparam logic CFG_OWN_ADDRESS = 1'b0;
    localparam logic CFG_IDENT_BYTE  = 1'b1;

    // bus commands
    localparam logic [7:0] CMD_READ_IDENT   = 8'h52;
    localparam logic [7:0] CMD_PWM          = 8'h53;
    localparam logic [7:0] CMD_GAIN         = 8'h54;
    localparam logic [7:0] CMD_SENSOR_FIRST = 8'h55;
    localparam logic [7:0] CMD_SENSOR_LAST  = 8'h59;
    localparam logic [7:0] CMD_BLOCK_FIRST  = 8'h5A;
    localparam logic [7:0] CMD_BLOCK_LAST   = 8'h5D;
    localparam logic [7:0] CMD_ADC          = 8'h5E;
    localparam logic [7:0] CMD_PINS         = 8'h5F;

    // event codes from the shift engine
    typedef enum logic [2:0] {
        OP_START    = 3'd0,
        OP_STOP     = 3'd1,
        OP_OVERFLOW = 3'd2,
        OP_LOAD     = 3'd3,
        OP_SWAP     = 3'd4
    } op_t;

    // action requested of the shift engine
    typedef enum logic [2:0] {
        ACT_WAIT_START = 3'd0,
        ACT_SEND_ACK   = 3'd1,
        ACT_SEND_TX    = 3'd2,
        ACT_READ_ACK   = 3'd3,
        ACT_READ_DATA  = 3'd4
    } act_t;

    // word in flight between the state update and the output register
    typedef struct packed {
        act_t       act;
        logic       upd_tx;
        logic       use_ram;
        logic       rd_ok;
        logic [7:0] imm;
        logic [7:0] pwm_b;
        logic [7:0] pwm_d;
        logic       gain_valid;
        logic [1:0] gain_code;
        logic       swap_accepted;
    } stage_t;

endpackage

/* rtl/i2ctci_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2ctci_ram
// Generic simple dual-port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module i2ctci_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 80
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while idle
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/i2c_target_command_interface.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_target_command_interface
// Register interface of a bus target fed by byte-level events.
// ----------------------------------------------------------------------------
// The slave channel takes one event word per handshake: the event code in
// s_tuser, the shifted byte, a load index and value and the pin levels in
// s_tdata. Every word yields exactly one master word holding the next action
// of the shift engine, the byte to send, both compare values, a gain request
// and the swap flag. Loads fill the write bank of a 2 x 40 byte sample store
// held in a ram; swaps exchange the banks unless a sensor or block read
// holds them. The accepting edge updates the control state and issues the
// ram read into the middle stage; the word moves into the output register
// once that register is empty or its word is being taken.
// One word is accepted every cycle while s_tready is high; the rate is set
// by the single ram read port, used at most once per word.
// While m_tready is low one further word is accepted and held in the middle
// stage; after that s_tready drops until the output register drains.
// Configuration writes (own address, identification byte) take effect at
// the edge.
// Reset is synchronous: control state, compare values and the store's valid
// bits return to their reset values at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module i2c_target_command_interface
    import i2ctci_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // event words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // bus_byte, load_index, load_value, pin_levels
    input  logic [2:0]  s_tuser,  // opcode
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // shifter_action, tx_byte, pwm_b_duty,
                                  // pwm_d_compare, gain_valid, gain_code,
                                  // swap_accepted, zero pad
);

    typedef enum logic [2:0] {
        PH_ADDR      = 3'd0,
        PH_SEND      = 3'd1,
        PH_REQ_REPLY = 3'd2,
        PH_CHK_REPLY = 3'd3,
        PH_REQ_DATA  = 3'd4,
        PH_GET_DATA  = 3'd5
    } phase_t;

    // input field split
    logic [7:0] in_bus_byte;
    logic [5:0] in_load_index;
    logic [7:0] in_load_value;
    logic [1:0] in_pins;

    assign in_bus_byte   = s_tdata[7:0];
    assign in_load_index = s_tdata[13:8];
    assign in_load_value = s_tdata[21:14];
    assign in_pins       = s_tdata[23:22];

    // state
    phase_t                 phase_reg, phase_next;
    logic                   listening_reg, listening_next;
    logic [7:0]             pos_reg, pos_next;
    logic [7:0]             cmd_reg, cmd_next;
    logic                   read_bank_reg, read_bank_next;
    logic                   locked_reg, locked_next;
    logic [7:0]             adc0_reg, adc0_next;
    logic [7:0]             adc1_reg, adc1_next;
    logic [7:0]             pwm_b_reg, pwm_b_next;
    logic [7:0]             pwm_d_reg, pwm_d_next;
    logic [6:0]             own_addr_reg;
    logic [7:0]             dev_id_reg;
    logic [STORE_DEPTH-1:0] valid_reg, valid_next;
    logic [7:0]             tx_hold_reg;
    stage_t                 p1_reg, p1_next;
    logic                   p1_valid_reg;
    logic                   m_tvalid_reg;
    logic [31:0]            m_tdata_reg;

    // handshake
    logic s_accept;
    logic m_load;

    assign s_tready = !p1_valid_reg || !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_load   = p1_valid_reg && (!m_tvalid_reg || m_tready);

    // ram access
    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic                ram_re;
    logic [STORE_AW-1:0] ram_raddr;
    logic [7:0]          ram_rdata;

    // working signals of the state update
    logic       tx_step;
    logic [7:0] cmd_eff;
    logic [7:0] pos_inc;
    logic [7:0] sensor_sub;
    logic [7:0] block_sub;
    logic [5:0] sensor_idx;
    logic [5:0] block_idx;
    logic [5:0] bank_idx;

    assign pos_inc    = pos_reg + {7'd0, (pos_reg != 8'hFF)};
    assign sensor_sub = cmd_reg - CMD_SENSOR_FIRST;
    assign block_sub  = cmd_reg - CMD_BLOCK_FIRST;
    assign sensor_idx = ({3'd0, pos_reg[2:0]} * 6'd5) + {3'd0, sensor_sub[2:0]};
    assign block_idx  = {2'd0, pos_reg[3:0]} + ({4'd0, block_sub[1:0]} * 6'd10);

    // event decode and control state update
    always_comb begin
        phase_next     = phase_reg;
        listening_next = listening_reg;
        pos_next       = pos_reg;
        cmd_next       = cmd_reg;
        read_bank_next = read_bank_reg;
        locked_next    = locked_reg;
        adc0_next      = adc0_reg;
        adc1_next      = adc1_reg;
        pwm_b_next     = pwm_b_reg;
        pwm_d_next     = pwm_d_reg;
        valid_next     = valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_re         = 1'b0;
        tx_step        = 1'b0;
        cmd_eff        = cmd_reg;
        bank_idx       = '0;
        p1_next        = p1_reg;
        p1_next.upd_tx        = 1'b0;
        p1_next.use_ram       = 1'b0;
        p1_next.imm           = 8'd0;
        p1_next.gain_valid    = 1'b0;
        p1_next.gain_code     = 2'd0;
        p1_next.swap_accepted = 1'b0;

        if (s_accept) begin
            case (s_tuser)
                OP_START: begin
                    phase_next     = PH_ADDR;
                    listening_next = 1'b1;
                end
                OP_STOP: begin
                    phase_next     = PH_ADDR;
                    listening_next = 1'b0;
                    pos_next       = 8'd0;
                end
                OP_OVERFLOW: begin
                    if (listening_reg) begin
                        case (phase_reg)
                            PH_ADDR: begin
                                if (in_bus_byte == GENERAL_CALL ||
                                    in_bus_byte[7:1] == own_addr_reg) begin
                                    pos_next   = 8'd0;
                                    phase_next = in_bus_byte[0] ? PH_SEND : PH_REQ_DATA;
                                end else begin
                                    listening_next = 1'b0;
                                end
                            end
                            PH_CHK_REPLY: begin
                                if (in_bus_byte != 8'd0) begin
                                    locked_next    = 1'b0;
                                    listening_next = 1'b0;
                                end else begin
                                    tx_step = 1'b1;
                                end
                            end
                            PH_SEND: begin
                                tx_step = 1'b1;
                            end
                            PH_REQ_REPLY: begin
                                phase_next = PH_CHK_REPLY;
                            end
                            PH_REQ_DATA: begin
                                phase_next = PH_GET_DATA;
                            end
                            PH_GET_DATA: begin
                                cmd_eff  = (pos_reg == 8'd0) ? in_bus_byte : cmd_reg;
                                cmd_next = cmd_eff;
                                if (cmd_eff == CMD_PWM) begin
                                    if (pos_reg == 8'd1) begin
                                        pwm_d_next = 8'hFF - in_bus_byte;
                                    end else if (pos_reg == 8'd2) begin
                                        pwm_b_next = in_bus_byte;
                                    end
                                end else if (cmd_eff == CMD_GAIN) begin
                                    if (pos_reg == 8'd1) begin
                                        p1_next.gain_valid = 1'b1;
                                        p1_next.gain_code  = in_bus_byte[1:0];
                                    end
                                end
                                pos_next   = pos_inc;
                                phase_next = PH_REQ_DATA;
                            end
                            default: begin
                                listening_next = 1'b0;
                                phase_next     = PH_ADDR;
                            end
                        endcase
                    end
                end
                OP_LOAD: begin
                    if (in_load_index < 6'(BANK_BYTES)) begin
                        ram_we    = 1'b1;
                        ram_waddr = read_bank_reg ? STORE_AW'(in_load_index)
                                  : STORE_AW'(in_load_index) + STORE_AW'(BANK_BYTES);
                        valid_next[ram_waddr] = 1'b1;
                    end else if (in_load_index == LOAD_ADC0) begin
                        adc0_next = in_load_value;
                    end else if (in_load_index == LOAD_ADC1) begin
                        adc1_next = in_load_value;
                    end
                end
                OP_SWAP: begin
                    if (!locked_reg) begin
                        read_bank_next        = !read_bank_reg;
                        p1_next.swap_accepted = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // choose the next byte to send
        if (tx_step) begin
            p1_next.upd_tx = 1'b1;
            if (cmd_reg == CMD_READ_IDENT) begin
                p1_next.imm = dev_id_reg;
            end else if (cmd_reg >= CMD_SENSOR_FIRST && cmd_reg <= CMD_SENSOR_LAST) begin
                if (pos_reg == 8'd0) locked_next = 1'b1;
                if (pos_reg < 8'd8) begin
                    p1_next.use_ram = 1'b1;
                    bank_idx        = sensor_idx;
                end
                if (pos_reg == 8'd7) locked_next = 1'b0;
            end else if (cmd_reg >= CMD_BLOCK_FIRST && cmd_reg <= CMD_BLOCK_LAST) begin
                if (pos_reg == 8'd0) locked_next = 1'b1;
                if (pos_reg < 8'd10) begin
                    p1_next.use_ram = 1'b1;
                    bank_idx        = block_idx;
                end
                if (pos_reg == 8'd9) locked_next = 1'b0;
            end else if (cmd_reg == CMD_ADC) begin
                if (pos_reg == 8'd0) p1_next.imm = adc0_reg;
                if (pos_reg == 8'd1) p1_next.imm = adc1_reg;
            end else if (cmd_reg == CMD_PINS) begin
                if (pos_reg == 8'd0) p1_next.imm = {2'd0, in_pins[1], 4'd0, in_pins[0]};
            end
            ram_re     = p1_next.use_ram;
            pos_next   = pos_inc;
            phase_next = PH_REQ_REPLY;
        end

        // action from the state after the word
        if (!listening_next) begin
            p1_next.act = ACT_WAIT_START;
        end else begin
            case (phase_next)
                PH_ADDR:      p1_next.act = ACT_READ_DATA;
                PH_SEND:      p1_next.act = ACT_SEND_ACK;
                PH_REQ_REPLY: p1_next.act = ACT_SEND_TX;
                PH_CHK_REPLY: p1_next.act = ACT_READ_ACK;
                PH_REQ_DATA:  p1_next.act = ACT_SEND_ACK;
                PH_GET_DATA:  p1_next.act = ACT_READ_DATA;
                default:      p1_next.act = ACT_WAIT_START;
            endcase
        end
        p1_next.pwm_b = pwm_b_next;
        p1_next.pwm_d = pwm_d_next;

        // read address in the read bank
        ram_raddr = read_bank_reg ? STORE_AW'(bank_idx) + STORE_AW'(BANK_BYTES)
                  : STORE_AW'(bank_idx);
        p1_next.rd_ok = valid_reg[ram_raddr];
    end

    // sample store
    i2ctci_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_load_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // second stage: merge ram data and form the result word
    logic [7:0]  bank_byte;
    logic [7:0]  tx_now;
    logic [7:0]  tx_out;
    logic [31:0] word_next;

    assign bank_byte = p1_reg.rd_ok ? ram_rdata : 8'd0;
    assign tx_now    = !p1_reg.upd_tx ? tx_hold_reg
                     : (p1_reg.use_ram ? bank_byte : p1_reg.imm);
    assign tx_out    = (p1_reg.act == ACT_SEND_TX) ? tx_now : 8'd0;
    assign word_next = {1'b0, p1_reg.swap_accepted, p1_reg.gain_code, p1_reg.gain_valid,
                        p1_reg.pwm_d, p1_reg.pwm_b, tx_out, p1_reg.act};

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_ADDR;
            listening_reg <= 1'b0;
            pos_reg       <= 8'd0;
            cmd_reg       <= 8'd0;
            read_bank_reg <= 1'b1;
            locked_reg    <= 1'b0;
            adc0_reg      <= 8'd0;
            adc1_reg      <= 8'd0;
            pwm_b_reg     <= 8'd0;
            pwm_d_reg     <= 8'hFF;
            own_addr_reg  <= OWN_ADDRESS_RST;
            dev_id_reg    <= 8'd0;
            valid_reg     <= '0;
            tx_hold_reg   <= 8'd0;
            p1_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            listening_reg <= listening_next;
            pos_reg       <= pos_next;
            cmd_reg       <= cmd_next;
            read_bank_reg <= read_bank_next;
            locked_reg    <= locked_next;
            adc0_reg      <= adc0_next;
            adc1_reg      <= adc1_next;
            pwm_b_reg     <= pwm_b_next;
            pwm_d_reg     <= pwm_d_next;
            valid_reg     <= valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_OWN_ADDRESS: own_addr_reg <= cfg_data[6:0];
                    CFG_IDENT_BYTE:  dev_id_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (s_accept) begin
                p1_valid_reg <= 1'b1;
            end else if (m_load) begin
                p1_valid_reg <= 1'b0;
            end
            if (m_load) begin
                tx_hold_reg  <= tx_now;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_reg <= p1_next;
        end
        if (m_load) begin
            m_tdata_reg <= word_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a swap while the read bank is held is never reported as done
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser == OP_SWAP && locked_reg |=> !p1_reg.swap_accepted)
        else $error("swap carried out while bank locked");

    // loads never reach the read bank
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (ram_waddr < STORE_AW'(BANK_BYTES)) == read_bank_reg)
        else $error("load written into read bank");

    // bank reads stay inside the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |-> ram_raddr < STORE_AW'(STORE_DEPTH))
        else $error("store read out of range");

    // a sent byte shows only with the send action
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != ACT_SEND_TX |-> m_tdata[10:3] == 8'd0)
        else $error("tx byte without send action");

endmodule
